[src/twdp_pkg.sv]
// ----------------------------------------------------------------------------
// twdp_pkg
// Shared widths, weight codes and register indexes for the ternary dot product.
// ----------------------------------------------------------------------------
package twdp_pkg;

    localparam int LANES      = 4;
    localparam int CODE_W     = 2;
    localparam int ACT_W      = 8;
    localparam int WEIGHT_W   = LANES * CODE_W;
    localparam int VLEN_W     = 13;
    localparam int COUNT_W    = 16;
    localparam int SUM_W      = 21;
    localparam int TERM_W     = ACT_W + 1;
    localparam int LANE_SUM_W = TERM_W + 2;
    localparam int LANE_CNT_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CODE_W-1:0] {
        CODE_ZERO = 2'd0,
        CODE_ADD  = 2'd1,
        CODE_SUB  = 2'd2,
        CODE_NONE = 2'd3
    } weight_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VECTOR_LENGTH = 2'd0,
        REG_COLUMN_COUNT  = 2'd1,
        REG_ROW_COUNT     = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef logic [ACT_W-1:0] act_t;
    typedef act_t [LANES-1:0] act_lanes_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0]   weight_byte;
        logic [LANE_CNT_W-1:0] lane_count;
    } lane_ctrl_t;

endpackage

[src/twdp_lane_sum.sv]
// ----------------------------------------------------------------------------
// twdp_lane_sum
// Signed sum of up to four activations, each added, subtracted or skipped
// by its 2-bit ternary weight code.
// ----------------------------------------------------------------------------
module twdp_lane_sum
    import twdp_pkg::*;
(
    input  lane_ctrl_t                     ctrl,
    input  act_lanes_t                     acts,
    output logic signed [LANE_SUM_W-1:0]   lane_sum
);

    always_comb
    begin
        weight_code_t             code;
        logic signed [TERM_W-1:0] term;
        logic signed [TERM_W-1:0] act_ext;
        lane_sum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            code    = weight_code_t'(ctrl.weight_byte[CODE_W*i +: CODE_W]);
            act_ext = TERM_W'(signed'(acts[i]));
            term    = '0;
            if (LANE_CNT_W'(i) < ctrl.lane_count)
            begin
                case (code)
                    CODE_ADD: term = act_ext;
                    CODE_SUB: term = -act_ext;
                    default:  term = '0;
                endcase
            end
            lane_sum = lane_sum + LANE_SUM_W'(term);
        end
    end

endmodule

[src/ternary_weight_dot_product.sv]
// ----------------------------------------------------------------------------
// ternary_weight_dot_product
// Streaming dot product of packed ternary weights with signed 8-bit
// activations, with column and row tracking over a matrix.
// ----------------------------------------------------------------------------
// One transaction carries one weight byte and four activations and is taken
// every cycle; its lane sum is folded into the running sum in the same cycle.
// A finished product lands in the output register in the cycle after its
// last transaction. s_tready drops only for a transaction that would finish
// a product while the output register still holds an untaken result, so
// transactions that do not finish a product flow on at one per cycle while
// the downstream side stalls. Configuration writes are taken at any cycle.
// ----------------------------------------------------------------------------
module ternary_weight_dot_product
    import twdp_pkg::*;
#(
    parameter int MAX_LENGTH  = 4096,
    parameter int MAX_COLUMNS = 65535,
    parameter int MAX_ROWS    = 65535
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // weight_byte [7:0], act_lane0 [15:8], act_lane1 [23:16],
    // act_lane2 [31:24], act_lane3 [39:32]
    input  logic [39:0]           s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // dot_sum [20:0], column_index [36:21], row_index [52:37], zero [55:53]
    output logic [55:0]           m_tdata,
    // row_end [0]
    output logic                  m_tuser,
    // matrix_end
    output logic                  m_tlast
);

    localparam int VLEN_MAX = (1 << VLEN_W) - 1;
    localparam logic [VLEN_W-1:0] LEN_CAP =
        VLEN_W'((MAX_LENGTH < VLEN_MAX) ? MAX_LENGTH : VLEN_MAX);
    localparam logic [COUNT_W-1:0] COL_CAP = COUNT_W'(MAX_COLUMNS);
    localparam logic [COUNT_W-1:0] ROW_CAP = COUNT_W'(MAX_ROWS);
    localparam int WIDE_W = SUM_W + 1;
    localparam logic signed [WIDE_W-1:0] SUM_HI = WIDE_W'((1 << (SUM_W - 1)) - 1);
    localparam logic signed [WIDE_W-1:0] SUM_LO = -WIDE_W'(1 << (SUM_W - 1));

    logic [VLEN_W-1:0]  vlen_reg;
    logic [COUNT_W-1:0] cols_reg;
    logic [COUNT_W-1:0] rows_reg;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [VLEN_W-1:0]       pos_reg, pos_next;
    logic [COUNT_W-1:0]      col_reg, col_next;
    logic [COUNT_W-1:0]      row_reg, row_next;

    logic                    m_tvalid_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic [COUNT_W-1:0]      out_col_reg;
    logic [COUNT_W-1:0]      out_row_reg;
    logic                    out_row_end_reg;
    logic                    out_mat_end_reg;

    logic [VLEN_W-1:0]  len_eff;
    logic [COUNT_W-1:0] cols_eff;
    logic [COUNT_W-1:0] rows_eff;
    logic [VLEN_W-1:0]  remaining;
    logic [LANE_CNT_W-1:0] lane_count;
    logic               done;
    logic               row_last;
    logic               mat_last;
    logic               in_acc;
    logic               out_acc;

    lane_ctrl_t                    ctrl;
    act_lanes_t                    acts;
    logic signed [LANE_SUM_W-1:0]  lane_sum;
    logic signed [WIDE_W-1:0]      sum_wide;
    logic signed [SUM_W-1:0]       sum_sat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlen_reg <= VLEN_W'(64);
            cols_reg <= COUNT_W'(1);
            rows_reg <= COUNT_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_VECTOR_LENGTH: vlen_reg <= cfg_data[VLEN_W-1:0];
                REG_COLUMN_COUNT:  cols_reg <= cfg_data[COUNT_W-1:0];
                REG_ROW_COUNT:     rows_reg <= cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (vlen_reg == '0)
            len_eff = VLEN_W'(1);
        else if (vlen_reg > LEN_CAP)
            len_eff = LEN_CAP;
        else
            len_eff = vlen_reg;

        if (cols_reg == '0)
            cols_eff = COUNT_W'(1);
        else if (cols_reg > COL_CAP)
            cols_eff = COL_CAP;
        else
            cols_eff = cols_reg;

        if (rows_reg == '0)
            rows_eff = COUNT_W'(1);
        else if (rows_reg > ROW_CAP)
            rows_eff = ROW_CAP;
        else
            rows_eff = rows_reg;
    end

    assign remaining  = (pos_reg < len_eff) ? (len_eff - pos_reg) : '0;
    assign done       = (remaining <= VLEN_W'(LANES));
    assign lane_count = done ? remaining[LANE_CNT_W-1:0] : LANE_CNT_W'(LANES);
    assign row_last   = (col_reg >= cols_eff - COUNT_W'(1));
    assign mat_last   = row_last && (row_reg >= rows_eff - COUNT_W'(1));

    assign s_tready = !done || !m_tvalid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid_reg && m_tready;

    assign ctrl.weight_byte = s_tdata[WEIGHT_W-1:0];
    assign ctrl.lane_count  = lane_count;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            acts[i] = s_tdata[WEIGHT_W + ACT_W*i +: ACT_W];
    end

    twdp_lane_sum u_lane_sum
    (
        .ctrl     (ctrl),
        .acts     (acts),
        .lane_sum (lane_sum)
    );

    always_comb
    begin
        sum_wide = WIDE_W'(sum_reg) + WIDE_W'(lane_sum);
        if (sum_wide > SUM_HI)
            sum_sat = SUM_HI[SUM_W-1:0];
        else if (sum_wide < SUM_LO)
            sum_sat = SUM_LO[SUM_W-1:0];
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end

    always_comb
    begin
        sum_next = sum_reg;
        pos_next = pos_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc)
        begin
            if (!done)
            begin
                sum_next = sum_sat;
                pos_next = pos_reg + VLEN_W'(lane_count);
            end
            else
            begin
                sum_next = '0;
                pos_next = '0;
                if (row_last)
                begin
                    col_next = '0;
                    row_next = mat_last ? '0 : row_reg + COUNT_W'(1);
                end
                else
                begin
                    col_next = col_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            pos_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            pos_reg <= pos_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (in_acc && done)
            m_tvalid_reg <= 1'b1;
        else if (out_acc)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && done)
        begin
            out_sum_reg     <= sum_sat;
            out_col_reg     <= col_reg;
            out_row_reg     <= row_reg;
            out_row_end_reg <= row_last;
            out_mat_end_reg <= mat_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_row_reg, out_col_reg, out_sum_reg};
    assign m_tuser  = out_row_end_reg;
    assign m_tlast  = out_mat_end_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready && in_acc) |-> !done)
        else $error("finishing transaction accepted over an untaken result");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && done) |=> m_tvalid_reg)
        else $error("finished product did not reach the output register");

    a_matrix_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (!out_mat_end_reg || out_row_end_reg))
        else $error("matrix end without row end");

    a_column_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && done && row_last) |=> (col_reg == '0 && pos_reg == '0))
        else $error("column counter did not wrap at row end");

    a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && done) |=> (sum_reg == '0))
        else $error("running sum not cleared after a finished product");

endmodule
